>>> rtl/core/smp_pkg.sv
// Shared types and constants for the streaming 2-D max pooling block.
// Used by smp_addr_gen, smp_max_store and stream_max_pool_2d.
// No dependencies.
package smp_pkg;

   // Feature map geometry
   localparam int IN_SIZE    = 24;
   localparam int OUT_SIZE   = 12;
   localparam int KERNEL     = 2;
   localparam int CHANNELS   = 8;
   localparam int DATA_WIDTH = 24;

   localparam int STORE_DEPTH = OUT_SIZE * CHANNELS;
   localparam int POOL_SPAN   = OUT_SIZE * KERNEL;

   // Counter and address widths
   localparam int ROW_W = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int K_W   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
   localparam int OC_W  = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Per-sample operation decoded from the position counters
   typedef struct packed {
      logic             keep;   // inside the pooled area
      logic             first;  // first sample of its window
      logic             last;   // last sample of its window
      logic [IDX_W-1:0] idx;    // row store entry
   } op_type;

   // Status of the read-modify-write stage towards the output register
   typedef struct packed {
      logic valid;  // stage holds a transaction
      logic emit;   // transaction produces a pooled value
   } st_type;

endpackage

>>> rtl/core/smp_addr_gen.sv
// Position counters for the incoming sample stream; decodes window flags
// and the row store index. Depends on smp_pkg.
module smp_addr_gen (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   output smp_pkg::op_type op
);
   import smp_pkg::*;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W-1:0] col_ff, col_in;
   logic [CH_W-1:0]  channel_ff, channel_in;
   logic [K_W-1:0]   krow_ff, krow_in;
   logic [K_W-1:0]   kcol_ff, kcol_in;
   logic [OC_W-1:0]  ocol_ff, ocol_in;

   logic ch_last, col_last, row_last, kcol_last, krow_last;

   assign ch_last   = (channel_ff == CH_W'(CHANNELS - 1));
   assign col_last  = (col_ff == ROW_W'(IN_SIZE - 1));
   assign row_last  = (row_ff == ROW_W'(IN_SIZE - 1));
   assign kcol_last = (kcol_ff == K_W'(KERNEL - 1));
   assign krow_last = (krow_ff == K_W'(KERNEL - 1));

   // Next position: channel, then column, then row
   always_comb begin
      channel_in = channel_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      kcol_in    = kcol_ff;
      krow_in    = krow_ff;
      ocol_in    = ocol_ff;
      if (step) begin
         channel_in = ch_last ? '0 : channel_ff + 1'b1;
         if (ch_last) begin
            col_in  = col_last ? '0 : col_ff + 1'b1;
            kcol_in = (col_last || kcol_last) ? '0 : kcol_ff + 1'b1;
            if (col_last) begin
               ocol_in = '0;
            end else if (kcol_last && (ocol_ff != OC_W'(OUT_SIZE - 1))) begin
               ocol_in = ocol_ff + 1'b1;
            end
            if (col_last) begin
               row_in  = row_last ? '0 : row_ff + 1'b1;
               krow_in = (row_last || krow_last) ? '0 : krow_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         channel_ff <= '0;
         krow_ff    <= '0;
         kcol_ff    <= '0;
         ocol_ff    <= '0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         channel_ff <= channel_in;
         krow_ff    <= krow_in;
         kcol_ff    <= kcol_in;
         ocol_ff    <= ocol_in;
      end
   end

   // Decode of the current position
   always_comb begin
      op.keep  = (32'(row_ff) < 32'(POOL_SPAN)) && (32'(col_ff) < 32'(POOL_SPAN));
      op.first = (krow_ff == '0) && (kcol_ff == '0);
      op.last  = krow_last && kcol_last;
      op.idx   = IDX_W'(32'(ocol_ff) * 32'(CHANNELS) + 32'(channel_ff));
   end

endmodule

>>> rtl/core/smp_max_store.sv
// Row store of running window maxima with its read-modify-write stage.
// Read on accept, compare and write back when the stage advances. Depends on smp_pkg.
module smp_max_store (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_accept,
   input  smp_pkg::op_type                    in_op,
   input  logic signed [smp_pkg::DATA_WIDTH-1:0] in_sample,
   input  logic                               advance,
   output smp_pkg::st_type                    status,
   output logic signed [smp_pkg::DATA_WIDTH-1:0] result
);
   import smp_pkg::*;

   logic [DATA_WIDTH-1:0] store_mem [STORE_DEPTH];

   logic                         s1_valid_ff;
   op_type                       op_ff;
   logic signed [DATA_WIDTH-1:0] sample_ff;
   logic [DATA_WIDTH-1:0]        rdata_ff;

   // Last write, forwarded to a read that raced it
   logic                  wr_valid_ff;
   logic [IDX_W-1:0]      wr_idx_ff;
   logic [DATA_WIDTH-1:0] wr_data_ff;

   logic signed [DATA_WIDTH-1:0] cur;
   logic signed [DATA_WIDTH-1:0] new_max;
   logic                         do_write;

   // Synchronous read port
   always_ff @(posedge clock) begin
      if (in_accept) begin
         rdata_ff <= store_mem[in_op.idx];
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[op_ff.idx] <= new_max;
      end
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         op_ff     <= in_op;
         sample_ff <= in_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (do_write) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         wr_idx_ff  <= op_ff.idx;
         wr_data_ff <= new_max;
      end
   end

   // Compare with forwarding from the latest write
   always_comb begin
      cur      = (wr_valid_ff && (wr_idx_ff == op_ff.idx)) ? wr_data_ff : rdata_ff;
      new_max  = (op_ff.first || (sample_ff > cur)) ? sample_ff : cur;
      do_write = advance && op_ff.keep;
   end

   assign status.valid = s1_valid_ff;
   assign status.emit  = op_ff.keep && op_ff.last;
   assign result       = new_max;

   a_adv_needs_valid: assert property (@(posedge clock) disable iff (reset)
      advance |-> s1_valid_ff)
      else $error("stage advanced while empty");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_accept && s1_valid_ff) |-> advance)
      else $error("new transaction overwrote a held one");

   a_fwd_tracks_write: assert property (@(posedge clock) disable iff (reset)
      do_write |=> (wr_valid_ff && (wr_idx_ff == $past(op_ff.idx))))
      else $error("forwarding register missed a write");

   a_first_overwrites: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && op_ff.first) |-> (result == sample_ff))
      else $error("first sample of a window did not overwrite the entry");

endmodule

>>> rtl/core/stream_max_pool_2d.sv
// Streaming 2-D max pooling, top level with the output register.
// Depends on smp_pkg, smp_addr_gen and smp_max_store.
//
// Usage:
//   req_ carries one signed sample per transaction in row, column, channel
//   order; rsp_ carries one pooled maximum per completed window, in the
//   order the windows complete (channel order within an output column).
//   A transaction moves when valid is high and stall is low.
// Path: a pooled value reaches rsp_ through the read-modify-write stage register
//   and then the output register, after the transaction carrying the last sample of its window.
// Throughput: one sample per cycle while req_stall is low. The row store is read as a
//   sample is taken and written back when the stage advances; a same-entry read that races the
//   write is served from a forwarding register, so back-to-back samples of
//   one window never wait.
// Reset: clears the position counters and the pipeline valids; the row store
//   is not cleared, since every entry is overwritten by the first sample of
//   its window before it is used. The first sample after reset is row 0,
//   column 0, channel 0.
// Stall: while rsp_stall holds a result, transactions keep passing the read stage until one
//   that completes a window reaches it; req_stall rises only when that stage holds a result too.
module stream_max_pool_2d (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [smp_pkg::DATA_WIDTH-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [smp_pkg::DATA_WIDTH-1:0] rsp_pooled_value
);
   import smp_pkg::*;

   op_type                       op;
   st_type                       st;
   logic signed [DATA_WIDTH-1:0] result;

   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff;

   logic rsp_free, s1_advance, req_accept;

   // Handshake
   always_comb begin
      rsp_free   = !rsp_valid_ff || !rsp_stall;
      s1_advance = st.valid && (!st.emit || rsp_free);
      req_stall  = st.valid && !s1_advance;
      req_accept = req_valid && !req_stall;
   end

   smp_addr_gen u_addr_gen (
      .clock (clock),
      .reset (reset),
      .step  (req_accept),
      .op    (op)
   );

   smp_max_store u_max_store (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_op     (op),
      .in_sample (req_sample),
      .advance   (s1_advance),
      .status    (st),
      .result    (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && st.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && st.emit) begin
         rsp_value_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_value_ff;

endmodule

>>> sim/stream_max_pool_2d_tb.sv
// Self-checking testbench for stream_max_pool_2d: extreme and random sample traffic with
// sender gaps and result back-pressure, checked against an in-bench pooling model.
// Depends on smp_pkg and the stream_max_pool_2d RTL.
`timescale 1ns / 1ps

module stream_max_pool_2d_tb;
   import smp_pkg::*;

   localparam int DW         = DATA_WIDTH;
   localparam int IDLE_LIMIT = 1000;
   localparam int REPORT_MAX = 10;

   localparam logic signed [DW-1:0] NEG_FULL = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] POS_FULL = {1'b0, {(DW-1){1'b1}}};

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   logic signed [DW-1:0] req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   logic signed [DW-1:0] rsp_pooled_value;

   // Pooling model state: running window maxima and position counters
   logic signed [DW-1:0] window_peak [STORE_DEPTH];
   int unsigned          pos_row = 0;
   int unsigned          pos_col = 0;
   int unsigned          pos_ch  = 0;
   logic signed [DW-1:0] pooled_q [$];

   int  fault_count = 0;
   int  idle_cycles = 0;
   int  stall_left  = 0;
   bit  rsp_jam_on  = 1'b0;

   stream_max_pool_2d i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pooled_value (rsp_pooled_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Fold one sample into its window; queue the maximum when the window closes
   function automatic void pool_track(logic signed [DW-1:0] s);
      int unsigned idx;
      bit          opens;
      bit          closes;
      if (pos_row < POOL_SPAN && pos_col < POOL_SPAN) begin
         idx    = (pos_col / KERNEL) * CHANNELS + pos_ch;
         opens  = (pos_row % KERNEL == 0) && (pos_col % KERNEL == 0);
         closes = (pos_row % KERNEL == KERNEL - 1) && (pos_col % KERNEL == KERNEL - 1);
         if (idx < STORE_DEPTH) begin
            if (opens || s > window_peak[idx])
               window_peak[idx] = s;
            if (closes)
               pooled_q.push_back(window_peak[idx]);
         end
      end
      // row, column, channel order; wraps at end of frame
      pos_ch++;
      if (pos_ch >= CHANNELS) begin
         pos_ch = 0;
         pos_col++;
         if (pos_col >= IN_SIZE) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= IN_SIZE)
               pos_row = 0;
         end
      end
   endfunction

   function automatic void log_fault(string what, logic signed [DW-1:0] want,
                                     logic signed [DW-1:0] got);
      if (fault_count < REPORT_MAX)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      fault_count++;
   endfunction

   // Accepted input transactions feed the model
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pool_track(req_sample);
   end

   // Each accepted result is checked against the oldest expected maximum
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pooled_q.size() == 0)
            log_fault("unexpected pooled value", '0, rsp_pooled_value);
         else if (rsp_pooled_value !== pooled_q[0])
            log_fault("pooled value mismatch", pooled_q.pop_front(), rsp_pooled_value);
         else
            void'(pooled_q.pop_front());
      end
   end

   // Receiver back-pressure: alternating free and stalled runs of random length
   always @(posedge clock) begin
      if (reset || !rsp_jam_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= ($urandom_range(3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 3);
      end
   end

   // Watchdog on cycles in which no transaction moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("stream_max_pool_2d regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [DW-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return NEG_FULL;
         1:       return POS_FULL;
         2:       return DW'($signed($urandom_range(0, 8)) - 4);
         default: return DW'($urandom);
      endcase
   endfunction

   // One input transaction; valid stays high so back-to-back sends need no gap
   task automatic send_sample(input logic signed [DW-1:0] s);
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Random samples in bursts, optionally with idle gaps between bursts
   task automatic send_run(input int count, input bit with_gaps);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         if (burst > left)
            burst = left;
         repeat (burst) send_sample(pick_sample());
         left -= burst;
         if (with_gaps && left > 0 && $urandom_range(3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pooled_q.size() != 0)
         @(posedge clock);
   endtask

   // Full-scale values and their neighbours, zero, 1, -1 and an alternating bit pattern, rotated per column
   task automatic test_extreme_samples();
      logic signed [DW-1:0] s;
      rsp_jam_on = 1'b0;
      for (int i = 0; i < 3 * CHANNELS; i++) begin
         case ((i + i / CHANNELS) % 8)
            0:       s = NEG_FULL;
            1:       s = POS_FULL;
            2:       s = '0;
            3:       s = '1;
            4:       s = DW'(1);
            5:       s = DW'(NEG_FULL + 1);
            6:       s = DW'(POS_FULL - 1);
            default: s = {(DW/2){2'b10}};
         endcase
         send_sample(s);
      end
   endtask

   // Bursty traffic under back-pressure, with a full drain halfway
   task automatic test_random_traffic();
      rsp_jam_on = 1'b1;
      send_run(600, 1'b1);
      wait_drained();
      send_run(600, 1'b1);
   endtask

   // Long runs with no sender idling, first with the receiver always ready
   task automatic test_back_to_back();
      rsp_jam_on = 1'b0;
      send_run(288, 1'b0);
      rsp_jam_on = 1'b1;
      send_run(288, 1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extreme_samples();
      test_random_traffic();
      test_back_to_back();

      wait_drained();
      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("stream_max_pool_2d regression: pass");
      else
         $display("stream_max_pool_2d regression: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/core/smp_pkg.sv
rtl/core/smp_addr_gen.sv
rtl/core/smp_max_store.sv
rtl/core/stream_max_pool_2d.sv
sim/stream_max_pool_2d_tb.sv
